// ===== hdl/lru_tlb_core_macros.svh =====
// assertion macros used by the checker file
`ifndef LRU_TLB_CORE_MACROS_SVH
`define LRU_TLB_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define LTLB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define LTLB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ltlb_pkg.sv =====
package ltlb_pkg;

	// command codes carried in tuser of the input stream
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// capacity register
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	// per cell control broadcast from the top level
	typedef struct packed {
		logic ins_go;  // insert transaction leaves stage 1 this cycle
		logic lkp_go;  // lookup transaction leaves stage 1 this cycle
		logic any_hit; // lookup matched somewhere in the chain
		logic keep;    // this cell lies within the kept range of an insert
	} cell_ctrl_t;

endpackage

// ===== hdl/ltlb_cell.sv =====
module ltlb_cell #(
	parameter int PAGE_BITS = 20,
	parameter int FRAME_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input ltlb_pkg::cell_ctrl_t ctrl,
	input logic [PAGE_BITS-1:0] lookup_page,
	input logic [PAGE_BITS-1:0] prev_page,
	input logic [FRAME_BITS-1:0] prev_frame,
	input logic hit_in,
	output logic hit_out,
	output logic [PAGE_BITS-1:0] page_out,
	output logic [FRAME_BITS-1:0] frame_out,
	output logic [FRAME_BITS-1:0] sel_frame
);
	import ltlb_pkg::*;

	logic used_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic match;
	logic load;

	// compare against the page in stage 1
	assign match = used_q && (page_q == lookup_page);
	assign hit_out = hit_in | match;

	// only the first match toward the front drives its frame
	assign sel_frame = (match && !hit_in) ? frame_q : '0;

	// take the neighbor's entry on an insert that keeps this cell, or when the hit lies at or behind this cell
	assign load = (ctrl.ins_go && ctrl.keep) || (ctrl.lkp_go && ctrl.any_hit && !hit_in);

	// in-use flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctrl.ins_go) begin
			used_q <= ctrl.keep;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (load) begin
			page_q <= prev_page;
			frame_q <= prev_frame;
		end
	end

	assign page_out = page_q;
	assign frame_out = frame_q;

endmodule

// ===== hdl/lru_tlb_core.sv =====
// Fully associative translation buffer kept in recency order.
// Input stream: tuser is the command (0 lookup, 1 insert), tdata carries
// page_number in the low bits and frame_in above it, padded to whole bytes.
// Output stream: tuser is hit, tdata carries frame_out padded to whole bytes.
// Every input transaction gives exactly one output transaction, in order.
// cfg_we/cfg_wdata write the capacity register (1..16 in use, zero acts as 1,
// values above ENTRIES act as ENTRIES); write it only while the block is idle.
// The input transaction is registered in stage 1, and its result in the output
// register, from which it is offered.
// Throughput: one transaction per cycle unless the receiver stalls; each item
// compares against the chain of ENTRIES cells in stage 1, and the chain shifts
// its entries at that cycle's end, so the next item already sees the new order.
// Reset empties the buffer and sets the capacity to 10.
// When the receiver stalls, the output register holds its result, stage 1
// holds its item and s_axis_tready drops until the output is taken.
module lru_tlb_core #(
	parameter int ENTRIES = 16,
	parameter int PAGE_BITS = 20,
	parameter int FRAME_BITS = 20,
	localparam int IN_DATA_W = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((FRAME_BITS + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ltlb_pkg::CAP_W-1:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [IN_DATA_W-1:0] s_axis_tdata,  // page_number, frame_in, zero pad
	input logic s_axis_tuser,                  // cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata, // frame_out, zero pad
	output logic m_axis_tuser                   // hit
);
	import ltlb_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int EW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] fill_q;

	logic valid_s1;
	logic cmd_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic [FRAME_BITS-1:0] frame_s1;

	logic out_valid_q;
	logic out_hit_q;
	logic [FRAME_BITS-1:0] out_frame_q;

	logic advance;
	logic ins_go;
	logic lkp_go;
	logic [EW-1:0] cap_ext;
	logic [EW-1:0] eff_cap;
	logic [EW-1:0] fill_ext;
	logic [EW-1:0] keep;
	logic [FRAME_BITS-1:0] hit_frame;
	logic [FRAME_BITS-1:0] front_frame;

	logic hit_chain [ENTRIES+1];
	logic [PAGE_BITS-1:0] page_chain [ENTRIES];
	logic [FRAME_BITS-1:0] frame_chain [ENTRIES];
	logic [FRAME_BITS-1:0] sel_frame [ENTRIES];
	cell_ctrl_t ctrl [ENTRIES];

	// handshake: stage 1 moves when the output register is free or being taken
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign ins_go = advance && (cmd_s1 == CMD_INSERT);
	assign lkp_go = advance && (cmd_s1 == CMD_LOOKUP);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// effective capacity and number of old entries kept on insert
	always_comb begin
		cap_ext = EW'(cap_q);
		fill_ext = EW'(fill_q);
		if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(ENTRIES)) begin
			eff_cap = EW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		if (fill_ext > (eff_cap - EW'(1))) begin
			keep = eff_cap - EW'(1);
		end else begin
			keep = fill_ext;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ins_go) begin
			fill_q <= CNT_W'(keep + EW'(1));
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= s_axis_tuser;
			page_s1 <= s_axis_tdata[PAGE_BITS-1:0];
			frame_s1 <= s_axis_tdata[PAGE_BITS +: FRAME_BITS];
		end
	end

	// per cell control
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			ctrl[j].ins_go = ins_go;
			ctrl[j].lkp_go = lkp_go;
			ctrl[j].any_hit = hit_chain[ENTRIES];
			ctrl[j].keep = (EW'(j) <= keep);
		end
	end

	// frame of the first matching cell
	always_comb begin
		hit_frame = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			hit_frame = hit_frame | sel_frame[j];
		end
	end

	assign front_frame = (cmd_s1 == CMD_INSERT) ? frame_s1 : hit_frame;
	assign hit_chain[0] = 1'b0;

	// chain of cells, front cell takes the new entry
	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		logic [PAGE_BITS-1:0] prev_page;
		logic [FRAME_BITS-1:0] prev_frame;

		if (j == 0) begin : g_front
			assign prev_page = page_s1;
			assign prev_frame = front_frame;
		end else begin : g_rest
			assign prev_page = page_chain[j-1];
			assign prev_frame = frame_chain[j-1];
		end

		ltlb_cell #(
			.PAGE_BITS(PAGE_BITS),
			.FRAME_BITS(FRAME_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl[j]),
			.lookup_page(page_s1),
			.prev_page(prev_page),
			.prev_frame(prev_frame),
			.hit_in(hit_chain[j]),
			.hit_out(hit_chain[j+1]),
			.page_out(page_chain[j]),
			.frame_out(frame_chain[j]),
			.sel_frame(sel_frame[j])
		);
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload, insert and miss answer zero
	always_ff @(posedge clk) begin
		if (advance) begin
			out_hit_q <= lkp_go && hit_chain[ENTRIES];
			out_frame_q <= (lkp_go && hit_chain[ENTRIES]) ? hit_frame : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_hit_q;
	assign m_axis_tdata = OUT_DATA_W'(out_frame_q);

endmodule

// ===== hdl/lru_tlb_core_chk.sv =====
`include "lru_tlb_core_macros.svh"

module lru_tlb_core_chk #(
	parameter int OUT_W = 24
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic m_axis_tuser
);

	// a stalled result stays offered
	`LTLB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")

	// a stalled result keeps its payload
	`LTLB_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "output payload changed while stalled")

	// a miss or an insert answers frame zero
	`LTLB_NEVER(a_miss_zero, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata != '0), "nonzero frame without hit")

	// a transaction taken with the output idle passes stage 1 and the output register and is then offered
	`LTLB_ASSERT(a_latency, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid, "result missing two cycles after input")

endmodule

bind lru_tlb_core lru_tlb_core_chk #(
	.OUT_W(OUT_DATA_W)
) u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
